// ----- hw/rtl/bthalloc_pkg.sv -----
// bthalloc_pkg: shared types and constants of the boundary-tag heap allocator.
// Holds the controller states, datapath operation codes, command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bthalloc_pkg;

    typedef enum logic [1:0] {
        ST_ALLOC = 2'd0,
        ST_ZERO  = 2'd1,
        ST_OOM   = 2'd2,
        ST_FREED = 2'd3
    } status_t;

    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_CHUNK_BYTES = 1'b1;

    localparam logic KIND_FREE = 1'b1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_FIT_RD,
        S_FIT_CHK,
        S_GROW,
        S_G_HDR,
        S_G_FTR,
        S_G_EPI,
        S_M_RDP,
        S_M_CAPP,
        S_M_CHK,
        S_M_HDR,
        S_M_FTR,
        S_PLACE,
        S_P_FTR,
        S_PS_FTR,
        S_PS_RHDR,
        S_PS_RFTR,
        S_FW_RD,
        S_FW_CHK,
        S_F_HDR,
        S_F_FTR,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_HDR,
        OP_ADVANCE,
        OP_TAKE,
        OP_GROW_BEGIN,
        OP_W_HDR,
        OP_W_FTR,
        OP_W_EPI,
        OP_RD_PREV,
        OP_CAP_PREV,
        OP_MERGE_CALC,
        OP_W_PHDR,
        OP_W_PFTR,
        OP_W_RHDR,
        OP_W_RFTR,
        OP_GRANT,
        OP_NOGRANT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   flag;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_free;
        logic req_zero;
        logic hdr_zero;
        logic hdr_alloc;
        logic fits;
        logic walk_more;
        logic free_hit;
        logic grow_ok;
        logic both_alloc;
        logic split;
    } dp_sts_t;

endpackage

// ----- hw/rtl/bthalloc_dp.sv -----
// bthalloc_dp: heap memory, config registers, block pointers and tag arithmetic.
// Executes one command per cycle from bthalloc_ctrl. Uses bthalloc_pkg.
`timescale 1ns / 1ps

module bthalloc_dp #(
    parameter int HEAP_WORD_COUNT = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [16:0]           cfg_data,
    input  logic                  kind,
    input  logic [16:0]           req_bytes,
    input  logic [15:0]           block_addr,
    input  bthalloc_pkg::cmd_t    cmd,
    output bthalloc_pkg::dp_sts_t sts,
    output logic [15:0]           grant_addr
);

    localparam int WW = $clog2(HEAP_WORD_COUNT);
    localparam int AW = (WW + 3 > 18) ? WW + 3 : 18;
    localparam logic [AW:0] HEAP_BYTES = (AW + 1)'(4 * HEAP_WORD_COUNT);
    localparam logic BIG = (HEAP_WORD_COUNT >= 1028);
    localparam logic [AW-1:0] BRK_INIT = BIG ? AW'(4112) : AW'(16);

    logic [31:0]   mem [HEAP_WORD_COUNT];
    logic [31:0]   rd_data_reg;
    logic          rd_oob_reg;

    logic [AW-1:0] brk_reg, rover_reg, bp_reg;
    logic [AW-1:0] size_reg, need_reg, prev_sz_reg;
    logic          prev_a_reg;
    logic [15:0]   addr_reg;
    logic          fit_reg;
    logic [16:0]   chunk_reg;
    logic [WW:0]   clr_reg;
    logic [15:0]   grant_reg;

    logic [31:0]   rdata;
    logic [AW-1:0] s;
    logic          ra;
    logic [AW-1:0] ext, gsize, need_calc;
    logic [AW:0]   grow_end;
    logic [17:0]   req_up;

    logic          re, we;
    logic [AW-1:0] raddr, waddr;
    logic [AW-3:0] rword, wword;
    logic [31:0]   wval;
    logic [31:0]   init_val;

    assign rdata = rd_oob_reg ? 32'd0 : rd_data_reg;
    assign s     = {rdata[AW-1:3], 3'b000};
    assign ra    = rdata[0];

    assign req_up    = (18'(req_bytes) + 18'd15) & ~18'd7;
    assign need_calc = (req_bytes <= 17'd8) ? AW'(16) : AW'(req_up);
    assign ext       = (need_reg > AW'(chunk_reg)) ? need_reg : AW'(chunk_reg);
    // word count rounded up to even, in bytes
    assign gsize     = {ext[AW-1:3] + (AW-3)'(ext[2]), 3'b000};
    assign grow_end  = (AW + 1)'(brk_reg) + (AW + 1)'(gsize);

    always_comb
    begin
        init_val = 32'd0;
        if (clr_reg == (WW + 1)'(1) || clr_reg == (WW + 1)'(2))
            init_val = 32'd9;
        else if (clr_reg == (WW + 1)'(3))
            init_val = BIG ? 32'd4096 : 32'd1;
        else if (BIG && clr_reg == (WW + 1)'(1026))
            init_val = 32'd4096;
        else if (BIG && clr_reg == (WW + 1)'(1027))
            init_val = 32'd1;
    end

    always_comb
    begin
        sts.clr_last   = (clr_reg == (WW + 1)'(HEAP_WORD_COUNT - 1));
        sts.in_free    = (kind == bthalloc_pkg::KIND_FREE);
        sts.req_zero   = (req_bytes == 17'd0);
        sts.hdr_zero   = (s == '0);
        sts.hdr_alloc  = ra;
        sts.fits       = (s >= need_reg);
        sts.walk_more  = (s != '0) && (bp_reg < AW'(addr_reg)) && (bp_reg < brk_reg);
        sts.free_hit   = (bp_reg == AW'(addr_reg)) && (s != '0) && ra;
        sts.grow_ok    = (gsize != '0) && (grow_end <= HEAP_BYTES);
        sts.both_alloc = prev_a_reg && ra;
        sts.split      = ((size_reg - need_reg) >= AW'(16));
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = bp_reg - AW'(4);
        we    = 1'b0;
        waddr = bp_reg - AW'(4);
        wval  = 32'(size_reg) | 32'(cmd.flag);
        case (cmd.op)
            bthalloc_pkg::OP_RD_HDR:   re = 1'b1;
            bthalloc_pkg::OP_ADVANCE:
            begin
                re    = 1'b1;
                raddr = bp_reg + s - AW'(4);
            end
            bthalloc_pkg::OP_RD_PREV:
            begin
                re    = 1'b1;
                raddr = bp_reg - AW'(8);
            end
            bthalloc_pkg::OP_CAP_PREV:
            begin
                re    = 1'b1;
                raddr = bp_reg + size_reg - AW'(4);
            end
            bthalloc_pkg::OP_CLEAR:    we = 1'b1;
            bthalloc_pkg::OP_W_HDR:    we = 1'b1;
            bthalloc_pkg::OP_W_FTR:
            begin
                we    = 1'b1;
                waddr = bp_reg + size_reg - AW'(8);
            end
            bthalloc_pkg::OP_W_EPI:
            begin
                we    = 1'b1;
                waddr = bp_reg + size_reg - AW'(4);
                wval  = 32'd1;
            end
            bthalloc_pkg::OP_W_PHDR:
            begin
                we   = 1'b1;
                wval = 32'(need_reg) | 32'd1;
            end
            bthalloc_pkg::OP_W_PFTR:
            begin
                we    = 1'b1;
                waddr = bp_reg + need_reg - AW'(8);
                wval  = 32'(need_reg) | 32'd1;
            end
            bthalloc_pkg::OP_W_RHDR:
            begin
                we    = 1'b1;
                waddr = bp_reg + need_reg - AW'(4);
                wval  = 32'(size_reg - need_reg);
            end
            bthalloc_pkg::OP_W_RFTR:
            begin
                we    = 1'b1;
                waddr = bp_reg + size_reg - AW'(8);
                wval  = 32'(size_reg - need_reg);
            end
            default: ;
        endcase
        if (cmd.op == bthalloc_pkg::OP_CLEAR)
        begin
            wval = init_val;
        end
    end

    assign rword = raddr[AW-1:2];
    assign wword = (cmd.op == bthalloc_pkg::OP_CLEAR) ? (AW - 2)'(clr_reg) : waddr[AW-1:2];

    // heap memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we && (wword < (AW - 2)'(HEAP_WORD_COUNT)))
            mem[wword[WW-1:0]] <= wval;
        if (re)
        begin
            rd_data_reg <= mem[rword[WW-1:0]];
            rd_oob_reg  <= (rword >= (AW - 2)'(HEAP_WORD_COUNT));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg   <= BRK_INIT;
            rover_reg <= AW'(8);
            bp_reg    <= AW'(16);
            fit_reg   <= 1'b0;
            chunk_reg <= 17'd4096;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == bthalloc_pkg::CFG_FIT_MODE)
                fit_reg <= cfg_data[0];
            if (cfg_we && cfg_index == bthalloc_pkg::CFG_CHUNK_BYTES)
                chunk_reg <= cfg_data;
            case (cmd.op)
                bthalloc_pkg::OP_CLEAR:      clr_reg <= clr_reg + (WW + 1)'(1);
                bthalloc_pkg::OP_LOAD:
                    bp_reg <= (kind == bthalloc_pkg::KIND_FREE) ? AW'(16)
                            : (fit_reg ? AW'(8) : rover_reg);
                bthalloc_pkg::OP_ADVANCE:    bp_reg <= bp_reg + s;
                bthalloc_pkg::OP_GROW_BEGIN: bp_reg <= brk_reg;
                bthalloc_pkg::OP_W_EPI:      brk_reg <= bp_reg + size_reg;
                bthalloc_pkg::OP_MERGE_CALC:
                begin
                    if (!prev_a_reg)
                    begin
                        bp_reg    <= bp_reg - prev_sz_reg;
                        rover_reg <= bp_reg - prev_sz_reg;
                    end
                    else
                    begin
                        rover_reg <= bp_reg;
                    end
                end
                bthalloc_pkg::OP_GRANT:      rover_reg <= bp_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bthalloc_pkg::OP_LOAD:
            begin
                addr_reg <= block_addr;
                need_reg <= need_calc;
            end
            bthalloc_pkg::OP_TAKE:       size_reg <= s;
            bthalloc_pkg::OP_GROW_BEGIN: size_reg <= gsize;
            bthalloc_pkg::OP_CAP_PREV:
            begin
                prev_a_reg  <= ra;
                prev_sz_reg <= s;
            end
            bthalloc_pkg::OP_MERGE_CALC:
                size_reg <= size_reg + (prev_a_reg ? AW'(0) : prev_sz_reg)
                          + (ra ? AW'(0) : s);
            bthalloc_pkg::OP_GRANT:      grant_reg <= bp_reg[15:0];
            bthalloc_pkg::OP_NOGRANT:    grant_reg <= 16'd0;
            default: ;
        endcase
    end

    assign grant_addr = grant_reg;

    a_bp_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        bp_reg[2:0] == 3'b000)
        else $error("block pointer misaligned");

    a_brk_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> brk_reg >= $past(brk_reg))
        else $error("heap break moved back");

    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (AW + 1)'(brk_reg) <= HEAP_BYTES || !BIG)
        else $error("heap break past memory");

endmodule

// ----- hw/rtl/bthalloc_ctrl.sv -----
// bthalloc_ctrl: sequencer of the allocator (init sweep, fit search, grow,
// coalesce, place, free walk) and the result word register. Uses bthalloc_pkg.
`timescale 1ns / 1ps

module bthalloc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bthalloc_pkg::status_t status,
    input  bthalloc_pkg::dp_sts_t sts,
    output bthalloc_pkg::cmd_t    cmd
);

    bthalloc_pkg::state_t  state_reg, state_next;
    bthalloc_pkg::status_t res_reg, res_next;
    bthalloc_pkg::status_t status_reg, status_next;
    logic                  after_free_reg, after_free_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept, out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bthalloc_pkg::S_INIT:
                if (sts.clr_last) state_next = bthalloc_pkg::S_IDLE;
            bthalloc_pkg::S_IDLE:
                if (in_valid)
                begin
                    if (sts.in_free)       state_next = bthalloc_pkg::S_FW_RD;
                    else if (sts.req_zero) state_next = bthalloc_pkg::S_DONE;
                    else                   state_next = bthalloc_pkg::S_FIT_RD;
                end
            bthalloc_pkg::S_FIT_RD:  state_next = bthalloc_pkg::S_FIT_CHK;
            bthalloc_pkg::S_FIT_CHK:
                if (sts.hdr_zero)                    state_next = bthalloc_pkg::S_GROW;
                else if (!sts.hdr_alloc && sts.fits) state_next = bthalloc_pkg::S_PLACE;
            bthalloc_pkg::S_GROW:
                state_next = sts.grow_ok ? bthalloc_pkg::S_G_HDR : bthalloc_pkg::S_DONE;
            bthalloc_pkg::S_G_HDR:   state_next = bthalloc_pkg::S_G_FTR;
            bthalloc_pkg::S_G_FTR:   state_next = bthalloc_pkg::S_G_EPI;
            bthalloc_pkg::S_G_EPI:   state_next = bthalloc_pkg::S_M_RDP;
            bthalloc_pkg::S_M_RDP:   state_next = bthalloc_pkg::S_M_CAPP;
            bthalloc_pkg::S_M_CAPP:  state_next = bthalloc_pkg::S_M_CHK;
            bthalloc_pkg::S_M_CHK:
                if (!sts.both_alloc)  state_next = bthalloc_pkg::S_M_HDR;
                else if (after_free_reg) state_next = bthalloc_pkg::S_DONE;
                else                  state_next = bthalloc_pkg::S_PLACE;
            bthalloc_pkg::S_M_HDR:   state_next = bthalloc_pkg::S_M_FTR;
            bthalloc_pkg::S_M_FTR:
                state_next = after_free_reg ? bthalloc_pkg::S_DONE : bthalloc_pkg::S_PLACE;
            bthalloc_pkg::S_PLACE:
                state_next = sts.split ? bthalloc_pkg::S_PS_FTR : bthalloc_pkg::S_P_FTR;
            bthalloc_pkg::S_P_FTR:   state_next = bthalloc_pkg::S_DONE;
            bthalloc_pkg::S_PS_FTR:  state_next = bthalloc_pkg::S_PS_RHDR;
            bthalloc_pkg::S_PS_RHDR: state_next = bthalloc_pkg::S_PS_RFTR;
            bthalloc_pkg::S_PS_RFTR: state_next = bthalloc_pkg::S_DONE;
            bthalloc_pkg::S_FW_RD:   state_next = bthalloc_pkg::S_FW_CHK;
            bthalloc_pkg::S_FW_CHK:
                if (!sts.walk_more)
                    state_next = sts.free_hit ? bthalloc_pkg::S_F_HDR : bthalloc_pkg::S_DONE;
            bthalloc_pkg::S_F_HDR:   state_next = bthalloc_pkg::S_F_FTR;
            bthalloc_pkg::S_F_FTR:   state_next = bthalloc_pkg::S_M_RDP;
            bthalloc_pkg::S_DONE:
                if (out_free) state_next = bthalloc_pkg::S_IDLE;
            default:                 state_next = bthalloc_pkg::S_INIT;
        endcase
    end

    always_comb
    begin
        cmd.op          = bthalloc_pkg::OP_NONE;
        cmd.flag        = 1'b0;
        in_ready        = 1'b0;
        res_next        = res_reg;
        after_free_next = after_free_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            bthalloc_pkg::S_INIT:    cmd.op = bthalloc_pkg::OP_CLEAR;
            bthalloc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op          = bthalloc_pkg::OP_LOAD;
                    after_free_next = sts.in_free;
                    if (sts.in_free)       res_next = bthalloc_pkg::ST_FREED;
                    else if (sts.req_zero) res_next = bthalloc_pkg::ST_ZERO;
                    else                   res_next = bthalloc_pkg::ST_ALLOC;
                end
            end
            bthalloc_pkg::S_FIT_RD:  cmd.op = bthalloc_pkg::OP_RD_HDR;
            bthalloc_pkg::S_FIT_CHK:
                if (sts.hdr_zero)                    cmd.op = bthalloc_pkg::OP_NONE;
                else if (!sts.hdr_alloc && sts.fits) cmd.op = bthalloc_pkg::OP_TAKE;
                else                                 cmd.op = bthalloc_pkg::OP_ADVANCE;
            bthalloc_pkg::S_GROW:
                if (sts.grow_ok) cmd.op = bthalloc_pkg::OP_GROW_BEGIN;
                else             res_next = bthalloc_pkg::ST_OOM;
            bthalloc_pkg::S_G_HDR:   cmd.op = bthalloc_pkg::OP_W_HDR;
            bthalloc_pkg::S_G_FTR:   cmd.op = bthalloc_pkg::OP_W_FTR;
            bthalloc_pkg::S_G_EPI:   cmd.op = bthalloc_pkg::OP_W_EPI;
            bthalloc_pkg::S_M_RDP:   cmd.op = bthalloc_pkg::OP_RD_PREV;
            bthalloc_pkg::S_M_CAPP:  cmd.op = bthalloc_pkg::OP_CAP_PREV;
            bthalloc_pkg::S_M_CHK:
                if (!sts.both_alloc) cmd.op = bthalloc_pkg::OP_MERGE_CALC;
            bthalloc_pkg::S_M_HDR:   cmd.op = bthalloc_pkg::OP_W_HDR;
            bthalloc_pkg::S_M_FTR:   cmd.op = bthalloc_pkg::OP_W_FTR;
            bthalloc_pkg::S_PLACE:
            begin
                cmd.op   = sts.split ? bthalloc_pkg::OP_W_PHDR : bthalloc_pkg::OP_W_HDR;
                cmd.flag = 1'b1;
            end
            bthalloc_pkg::S_P_FTR:
            begin
                cmd.op   = bthalloc_pkg::OP_W_FTR;
                cmd.flag = 1'b1;
            end
            bthalloc_pkg::S_PS_FTR:  cmd.op = bthalloc_pkg::OP_W_PFTR;
            bthalloc_pkg::S_PS_RHDR: cmd.op = bthalloc_pkg::OP_W_RHDR;
            bthalloc_pkg::S_PS_RFTR: cmd.op = bthalloc_pkg::OP_W_RFTR;
            bthalloc_pkg::S_FW_RD:   cmd.op = bthalloc_pkg::OP_RD_HDR;
            bthalloc_pkg::S_FW_CHK:
                if (sts.walk_more)     cmd.op = bthalloc_pkg::OP_ADVANCE;
                else if (sts.free_hit) cmd.op = bthalloc_pkg::OP_TAKE;
            bthalloc_pkg::S_F_HDR:   cmd.op = bthalloc_pkg::OP_W_HDR;
            bthalloc_pkg::S_F_FTR:   cmd.op = bthalloc_pkg::OP_W_FTR;
            bthalloc_pkg::S_DONE:
                if (out_free)
                begin
                    cmd.op = (res_reg == bthalloc_pkg::ST_ALLOC) ? bthalloc_pkg::OP_GRANT
                                                                  : bthalloc_pkg::OP_NOGRANT;
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bthalloc_pkg::S_INIT;
            res_reg        <= bthalloc_pkg::ST_ALLOC;
            after_free_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= bthalloc_pkg::ST_ALLOC;
        end
        else
        begin
            state_reg      <= state_next;
            res_reg        <= res_next;
            after_free_reg <= after_free_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while busy");

    a_word_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == bthalloc_pkg::S_DONE)
        else $error("result word raised outside completion");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> cmd.op != bthalloc_pkg::OP_GRANT
                                          && cmd.op != bthalloc_pkg::OP_NOGRANT)
        else $error("pending result word overwritten");

endmodule

// ----- hw/rtl/boundary_tag_heap_allocator_core.sv -----
// Boundary-tag heap allocator: each request walks the block headers it visits, then
// does any grow/coalesce/split writes; a zero-size request goes straight to its result.
// Throughput: one request at a time; the next word can be taken once the result is registered.
// Reset: a sweep over all HEAP_WORD_COUNT words writes the initial heap image; no
// request is accepted until it ends (config writes are taken throughout).
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_core #(
    parameter int HEAP_WORD_COUNT = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [16:0] req_bytes,
    input  logic [15:0] block_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] grant_addr,
    output logic [1:0]  status
);

    bthalloc_pkg::cmd_t    cmd;
    bthalloc_pkg::dp_sts_t sts;
    bthalloc_pkg::status_t status_w;

    bthalloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status_w),
        .sts       (sts),
        .cmd       (cmd)
    );

    bthalloc_dp #(
        .HEAP_WORD_COUNT (HEAP_WORD_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .req_bytes  (req_bytes),
        .block_addr (block_addr),
        .cmd        (cmd),
        .sts        (sts),
        .grant_addr (grant_addr)
    );

    assign status = status_w;

endmodule

// ----- verif/tb_boundary_tag_heap_allocator_core.sv -----
// Testbench for boundary_tag_heap_allocator_core: directed table, then random
// alloc/free traffic checked against an in-bench heap predictor.
// Depends on bthalloc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_boundary_tag_heap_allocator_core;

    localparam int HW = 16384;
    localparam bit [63:0] HEAP_BYTES = 64'(HW) * 4;

    typedef struct {
        bit                    kind;
        bit [16:0]             req;
        bit [15:0]             addr;
        bit                    use_last;
        bit                    chk;
        bit [15:0]             ea;
        bthalloc_pkg::status_t es;
    } row_t;

    typedef struct {
        bit [15:0]             ga;
        bthalloc_pkg::status_t st;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = bthalloc_pkg::CFG_FIT_MODE;
    logic [16:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [16:0] req_bytes = '0;
    logic [15:0] block_addr = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] grant_addr;
    logic [1:0]  status;

    bit [31:0] heap_mem [HW];
    bit [63:0] heap_brk, rover;
    bit        fit_first;
    bit [16:0] chunk_sz;

    word_t     exp_q[$];
    bit [15:0] live_blocks[$];
    int        mismatches = 0;
    bit        send_idle = 0, recv_stall = 0;

    boundary_tag_heap_allocator_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [31:0] hrd(bit [63:0] a);
        return ((a >> 2) < HW) ? heap_mem[a >> 2] : 32'd0;
    endfunction

    function automatic void hwr(bit [63:0] a, bit [31:0] v);
        if ((a >> 2) < HW)
            heap_mem[a >> 2] = v;
    endfunction

    function automatic bit [63:0] bsize(bit [63:0] bp);
        return {32'd0, hrd(bp - 4) & ~32'h7};
    endfunction

    function automatic void tags(bit [63:0] bp, bit [63:0] sz, bit a);
        hwr(bp - 4, sz[31:0] | 32'(a));
        hwr(bp + sz - 8, sz[31:0] | 32'(a));
    endfunction

    function automatic bit [63:0] coalesce(bit [63:0] bp);
        bit [63:0] sz, psz, nsz;
        bit        pa, na;
        sz  = bsize(bp);
        pa  = (hrd(bp - 8) & 32'd1) != 0;
        psz = {32'd0, hrd(bp - 8) & ~32'h7};
        na  = (hrd(bp + sz - 4) & 32'd1) != 0;
        nsz = bsize(bp + sz);
        if (pa && na)
            return bp;
        if (pa)
            sz += nsz;
        else if (na)
        begin
            sz += psz;
            bp -= psz;
        end
        else
        begin
            sz += psz + nsz;
            bp -= psz;
        end
        tags(bp, sz, 1'b0);
        rover = bp;
        return bp;
    endfunction

    function automatic bit [63:0] extend(bit [63:0] bytes);
        bit [63:0] sz, bp;
        sz = (((bytes / 4) + 1) & ~64'd1) * 4;
        bp = heap_brk;
        if (sz == 0 || bp + sz > HEAP_BYTES)
            return 0;
        tags(bp, sz, 1'b0);
        hwr(bp + sz - 4, 32'd1);
        heap_brk = bp + sz;
        return coalesce(bp);
    endfunction

    function automatic void heap_reset();
        bit [63:0] unused;
        foreach (heap_mem[i])
            heap_mem[i] = 0;
        fit_first = 0;
        chunk_sz  = 17'd4096;
        hwr(4, 32'd9);
        hwr(8, 32'd9);
        hwr(12, 32'd1);
        heap_brk = 16;
        unused = extend(4096);
        rover = 8;
    endfunction

    function automatic word_t heap_request(bit k, bit [16:0] req, bit [15:0] addr);
        word_t     r;
        bit [63:0] bp, need, cur;
        r.ga = '0;
        if (k == bthalloc_pkg::KIND_FREE)
        begin
            bp = 16;
            while (bsize(bp) != 0 && bp < addr && bp < heap_brk)
                bp += bsize(bp);
            if (bp == addr && bsize(bp) != 0 && ((hrd(bp - 4) & 32'd1) != 0))
            begin
                tags(bp, bsize(bp), 1'b0);
                bp = coalesce(bp);
            end
            r.st = bthalloc_pkg::ST_FREED;
            return r;
        end
        if (req == 0)
        begin
            r.st = bthalloc_pkg::ST_ZERO;
            return r;
        end
        need = (req <= 8) ? 64'd16 : 8 * ((64'(req) + 15) / 8);
        bp = fit_first ? 64'd8 : rover;
        while (bsize(bp) != 0 && (((hrd(bp - 4) & 32'd1) != 0) || bsize(bp) < need))
            bp += bsize(bp);
        if (bsize(bp) == 0)
        begin
            bp = extend(need > chunk_sz ? need : 64'(chunk_sz));
            if (bp == 0)
            begin
                r.st = bthalloc_pkg::ST_OOM;
                return r;
            end
        end
        cur = bsize(bp);
        if (cur - need >= 16)
        begin
            tags(bp, need, 1'b1);
            tags(bp + need, cur - need, 1'b0);
        end
        else
            tags(bp, cur, 1'b1);
        rover = bp;
        r.ga = bp[15:0];
        r.st = bthalloc_pkg::ST_ALLOC;
        return r;
    endfunction

    always @(negedge clk)
        out_ready <= !(recv_stall && $urandom_range(99) < 57);

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (exp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: grant_addr=%0d status=%0d", grant_addr, status);
            end
            else if (grant_addr !== exp_q[0].ga || status !== exp_q[0].st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp grant_addr=%0d status=%0d, got %0d/%0d",
                             exp_q[0].ga, exp_q[0].st, grant_addr, status);
                void'(exp_q.pop_front());
            end
            else
                void'(exp_q.pop_front());
        end
    end

    task automatic cfg_write(bit idx, bit [16:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == bthalloc_pkg::CFG_FIT_MODE)
            fit_first = val[0];
        else
            chunk_sz = val;
    endtask

    // drive one request word; caller is at a falling edge
    task automatic send_word(bit k, bit [16:0] req, bit [15:0] addr, bit chk,
                             bit [15:0] ea, bthalloc_pkg::status_t es);
        word_t w;
        while (send_idle && $urandom_range(99) < 57)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind       = k;
        req_bytes  = req;
        block_addr = addr;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        w = heap_request(k, req, addr);
        if (w.st == bthalloc_pkg::ST_ALLOC)
            live_blocks.push_back(w.ga);
        if (chk)
        begin
            w.ga = ea;
            w.st = es;
        end
        exp_q.push_back(w);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    initial
    begin
        row_t      dir[];
        bit [16:0] req;
        bit [15:0] addr;
        bit [15:0] last_grant;
        int        idx, pick;
        int        ph_fit[5]   = '{0, 1, 0, 1, 0};
        int        ph_chunk[5] = '{4096, 8, 65536, 1024, 16};
        dir = '{
            '{0, 1, 0, 0, 1, 16, bthalloc_pkg::ST_ALLOC},
            '{0, 0, 0, 0, 1, 0, bthalloc_pkg::ST_ZERO},
            '{0, 65536, 0, 0, 1, 0, bthalloc_pkg::ST_OOM},
            '{0, 65535, 0, 0, 1, 0, bthalloc_pkg::ST_OOM},
            '{1, 0, 16, 0, 1, 0, bthalloc_pkg::ST_FREED},
            '{1, 0, 16, 0, 1, 0, bthalloc_pkg::ST_FREED},
            '{1, 0, 16'hFFFF, 0, 1, 0, bthalloc_pkg::ST_FREED},
            '{1, 0, 0, 0, 1, 0, bthalloc_pkg::ST_FREED},
            '{0, 8, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{0, 9, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{0, 24, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{1, 0, 0, 1, 0, 0, bthalloc_pkg::ST_FREED},
            '{0, 4096, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{0, 4081, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{1, 0, 0, 1, 0, 0, bthalloc_pkg::ST_FREED},
            '{0, 16, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{1, 0, 0, 1, 0, 0, bthalloc_pkg::ST_FREED},
            '{1, 0, 0, 1, 0, 0, bthalloc_pkg::ST_FREED},
            '{0, 60000, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{0, 60000, 0, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{0, 1, 16'h5555, 0, 0, 0, bthalloc_pkg::ST_ALLOC},
            '{1, 0, 16'hAAAA, 0, 0, 0, bthalloc_pkg::ST_FREED}
        };
        heap_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        cfg_write(bthalloc_pkg::CFG_FIT_MODE, 17'd0);
        cfg_write(bthalloc_pkg::CFG_CHUNK_BYTES, 17'd4096);
        last_grant = 0;
        foreach (dir[i])
        begin
            addr = dir[i].use_last ? last_grant : dir[i].addr;
            send_word(dir[i].kind, dir[i].req, addr, dir[i].chk, dir[i].ea, dir[i].es);
            if (live_blocks.size() != 0)
                last_grant = live_blocks[$];
        end
        for (int ph = 0; ph < 5; ph++)
        begin
            wait (exp_q.size() == 0);
            repeat (4) @(posedge clk);
            send_idle  = (ph == 1 || ph == 3);
            recv_stall = (ph == 2 || ph == 3);
            cfg_write(bthalloc_pkg::CFG_FIT_MODE, 17'(ph_fit[ph]));
            cfg_write(bthalloc_pkg::CFG_CHUNK_BYTES, 17'(ph_chunk[ph]));
            live_blocks.delete();
            for (int n = 0; n < 240; n++)
            begin
                pick = int'($urandom_range(99));
                if (pick < 3)
                    send_word(1'b0, 17'd0, 16'($urandom), 1'b0, 16'd0,
                              bthalloc_pkg::ST_ALLOC);
                else if (pick < 8)
                    send_word(1'b1, 17'($urandom), 16'($urandom), 1'b0, 16'd0,
                              bthalloc_pkg::ST_FREED);
                else if (pick < 10)
                    send_word(1'b0, 17'($urandom_range(65536, 8192)), 16'd0, 1'b0, 16'd0,
                              bthalloc_pkg::ST_ALLOC);
                else if (pick < 48 && live_blocks.size() != 0)
                begin
                    idx  = int'($urandom_range(live_blocks.size() - 1));
                    addr = live_blocks[idx];
                    live_blocks.delete(idx);
                    // occasional double free
                    if ($urandom_range(9) == 0)
                        live_blocks.push_back(addr);
                    send_word(1'b1, 17'($urandom), addr, 1'b0, 16'd0,
                              bthalloc_pkg::ST_FREED);
                end
                else
                begin
                    req = ($urandom_range(9) == 0) ? 17'($urandom_range(4096, 1))
                                                   : 17'($urandom_range(128, 1));
                    send_word(1'b0, req, 16'($urandom), 1'b0, 16'd0,
                              bthalloc_pkg::ST_ALLOC);
                end
            end
        end
        send_idle = 0;
        wait (exp_q.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && exp_q.size() == 0)
            $display("[boundary_tag_heap_allocator_core] OK");
        else
            $display("[boundary_tag_heap_allocator_core] ERROR");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("[boundary_tag_heap_allocator_core] ERROR");
        $finish;
    end

endmodule
